>>> rtl/core/pln_pkg.sv
package pln_pkg;

   // Widths fixed by the register and field definitions.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCATTER_PCT = CSR_IDX_W'(1);

   // Fractional bits of the base-2 logarithm, one squaring per bit.
   localparam int LOG_STEPS = 30;
   // Configuration engine: a setup step, LOG_STEPS squaring steps, then a finishing step.
   localparam int CFG_DONE  = LOG_STEPS + 1;
   localparam int CFG_CNT_W = $clog2(CFG_DONE + 1);

   localparam logic [25:0] LN2_Q26      = 26'd46516320;
   localparam logic [35:0] LOG2_1E5_Q30 = 36'd17834465659;
   localparam logic [23:0] OFFSET_MAX   = 24'hFF_FFFF;
   localparam logic [31:0] PCT_ROUND    = 32'd50;
   // Division by 100 as a multiply by 2^37 / 100 rounded up, exact for any
   // 32-bit numerator.
   localparam logic [31:0] PCT_RECIP    = 32'h51EB_851F;
   localparam int          PCT_SHIFT    = 37;

   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [15:0] attenuation;
      logic               over_white;
      logic               floored;
      logic               last_out;
   } rsp_type;

   // Values the configuration engine derives once per register write.
   typedef struct packed {
      logic        busy;
      logic [15:0] white;
      logic [23:0] offset;
      logic [33:0] log2w;
      logic [35:0] dfloor;
   } cfg_type;

   // One fraction bit of log2: square the Q1.31 mantissa and renormalize.
   // Returns the new bit on top of the next mantissa.
   function automatic logic [32:0] sq_step(input logic [31:0] m);
      logic [63:0] p;
      p = 64'(m) * 64'(m);
      if (p[63]) begin
         sq_step = {1'b1, p[63:32]};
      end else begin
         sq_step = {1'b0, p[62:31]};
      end
   endfunction

   // Top set bit index and the value shifted so that bit sits at position 31.
   function automatic logic [36:0] normalize(input logic [23:0] x);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      normalize = {e, 32'(x) << (5'd31 - e)};
   endfunction

endpackage

>>> rtl/core/pln_cfg.sv
module pln_cfg import pln_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg_out
);

   logic [15:0]          white_ff, white_in;
   logic [14:0]          scat_ff, scat_in;
   logic                 busy_ff, busy_in;
   logic [CFG_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          m_ff, m_in;
   logic [3:0]           e_ff, e_in;
   logic [LOG_STEPS-1:0] frac_ff, frac_in;
   logic [31:0]          num_ff, num_in;
   logic [23:0]          offset_ff, offset_in;
   logic [33:0]          log2w_ff, log2w_in;
   logic [35:0]          dfloor_ff, dfloor_in;

   logic [15:0] w_eff;
   logic [36:0] norm;
   logic [32:0] sq;
   logic [63:0] pct_prod;
   logic [26:0] pct_quo;
   logic        wr;

   assign csr_ready = !busy_ff;
   assign wr        = csr_valid && csr_ready;
   // A white level of zero normalizes as if it were one.
   assign w_eff     = (white_ff == 16'd0) ? 16'd1 : white_ff;
   assign norm      = normalize(24'(w_eff));
   assign sq        = sq_step(m_ff);
   // Rounded scatter offset: (white * scatter + 50) / 100 by reciprocal multiply.
   assign pct_prod  = 64'(num_ff) * 64'(PCT_RECIP);
   assign pct_quo   = pct_prod[63:PCT_SHIFT];

   always_comb begin
      white_in  = white_ff;
      scat_in   = scat_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      m_in      = m_ff;
      e_in      = e_ff;
      frac_in   = frac_ff;
      num_in    = num_ff;
      offset_in = offset_ff;
      log2w_in  = log2w_ff;
      dfloor_in = dfloor_ff;
      if (wr) begin
         case (csr_index)
            CSR_WHITE_LEVEL: white_in = csr_wdata;
            CSR_SCATTER_PCT: scat_in  = csr_wdata[14:0];
            default: ;
         endcase
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CFG_CNT_W'(1);
         if (cnt_ff == '0) begin
            e_in    = norm[35:32];
            m_in    = norm[31:0];
            frac_in = '0;
            num_in  = 32'(w_eff) * 32'(scat_ff) + PCT_ROUND;
         end else if (cnt_ff == CFG_CNT_W'(CFG_DONE)) begin
            offset_in = (pct_quo > 27'(OFFSET_MAX)) ? OFFSET_MAX : pct_quo[23:0];
            log2w_in  = {e_ff, frac_ff};
            dfloor_in = 36'({e_ff, frac_ff}) + LOG2_1E5_Q30;
            busy_in   = 1'b0;
            cnt_in    = '0;
         end else begin
            // One fraction bit of log2 of the white level per cycle.
            m_in    = sq[31:0];
            frac_in = {frac_ff[LOG_STEPS-2:0], sq[32]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= 16'hFFFF;
         scat_ff  <= '0;
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         white_ff <= white_in;
         scat_ff  <= scat_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
      end
      m_ff      <= m_in;
      e_ff      <= e_in;
      frac_ff   <= frac_in;
      num_ff    <= num_in;
      offset_ff <= offset_in;
      log2w_ff  <= log2w_in;
      dfloor_ff <= dfloor_in;
   end

   assign cfg_out.busy   = busy_ff;
   assign cfg_out.white  = white_ff;
   assign cfg_out.offset = offset_ff;
   assign cfg_out.log2w  = log2w_ff;
   assign cfg_out.dfloor = dfloor_ff;

   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> busy_ff)
      else $error("register write did not start the derivation");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cnt_ff == CFG_CNT_W'(CFG_DONE)) |=> !busy_ff)
      else $error("configuration engine overran its last step");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !(csr_valid && csr_ready) |=> $stable(dfloor_ff) && $stable(offset_ff))
      else $error("derived values changed while idle");

endmodule

>>> rtl/core/projection_log_normalizer.sv
// A request passes the input, scatter, log2 chain, distance, scale and result registers.
// Throughput: one request per cycle while rsp is not stalled and the configuration engine
// is idle. A stall on rsp freezes every stage but the input register. After reset, and after
// every register write, the configuration engine computes log2 of the white level one bit
// per cycle, then the scatter offset, and req_ready and csr_ready are low meanwhile. Reset
// is synchronous, active high, and restores white_level to 65535 and scatter_pct to 0.
module projection_log_normalizer import pln_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic floored;
      logic over_white;
      logic last;
   } flag_type;

   // 8.0 in Q30, the gain of the Q.8 pixel scale.
   localparam logic [37:0] LOG2_256_Q30 = 38'd8 << 30;
   localparam logic [61:0] ROUND_HALF   = 62'd1 << 45;
   localparam logic [15:0] R_CLAMP      = 16'd40000;
   localparam logic [15:0] POS_MAX      = 16'd32767;
   localparam logic [15:0] NEG_MAG_MAX  = 16'd32768;

   // The configuration engine holds the registers and the values derived from
   // them: the scatter offset, log2 of the white level, and the distance used
   // for floored pixels.
   cfg_type cfg_st;

   pln_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_out   (cfg_st)
   );

   // Every stage moves on together whenever the result register is free or
   // being drained. The input register may still fill a bubble while a
   // result waits, so one request can be taken during an rsp stall.
   logic adv;
   logic accept;

   logic    a_vld_ff, a_vld_in;
   req_type a_pay_ff, a_pay_in;

   logic        b_vld_ff, b_vld_in;
   logic [24:0] b_v_ff, b_v_in;
   flag_type    b_flg_ff, b_flg_in;

   // The log2 chain: entry 0 holds the normalized value, entry k holds the
   // mantissa after k squarings and the k fraction bits found so far.
   logic [LOG_STEPS:0]   lg_vld_ff, lg_vld_in;
   logic [31:0]          lg_m_ff    [0:LOG_STEPS];
   logic [31:0]          lg_m_in    [0:LOG_STEPS];
   logic [LOG_STEPS-1:0] lg_frac_ff [0:LOG_STEPS];
   logic [LOG_STEPS-1:0] lg_frac_in [0:LOG_STEPS];
   logic [4:0]           lg_e_ff    [0:LOG_STEPS];
   logic [4:0]           lg_e_in    [0:LOG_STEPS];
   flag_type             lg_flg_ff  [0:LOG_STEPS];
   flag_type             lg_flg_in  [0:LOG_STEPS];

   logic        d_vld_ff, d_vld_in;
   logic [35:0] d_mag_ff, d_mag_in;
   logic        d_neg_ff, d_neg_in;
   flag_type    d_flg_ff, d_flg_in;

   logic        e_vld_ff, e_vld_in;
   logic [57:0] e_lo_ff, e_lo_in;
   logic [29:0] e_hi_ff, e_hi_in;
   logic        e_neg_ff, e_neg_in;
   flag_type    e_flg_ff, e_flg_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [36:0] norm;
   logic [34:0] lv;
   logic [37:0] ldiff;
   logic [61:0] sum;
   logic [61:0] rnd;
   logic [15:0] rmag;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = !cfg_st.busy && (adv || !a_vld_ff);
   assign accept    = req_valid && req_ready;

   // Input register.
   always_comb begin
      a_vld_in = accept || (a_vld_ff && !adv);
      a_pay_in = accept ? req_payload : a_pay_ff;
   end

   // Scatter correction. The corrected value is Q.8 and signed; anything
   // below 1.0 (including a negative result) takes the floor path.
   always_comb begin
      b_vld_in            = a_vld_ff;
      b_v_in              = 25'({a_pay_ff.pixel, 8'h00}) - 25'(cfg_st.offset);
      b_flg_in.floored    = b_v_in[24] || (b_v_in[23:8] == 16'd0);
      b_flg_in.over_white = a_pay_ff.pixel > cfg_st.white;
      b_flg_in.last       = a_pay_ff.last;
   end

   // Normalization and the squaring chain. A floored value never reaches the
   // result, so its mantissa only needs to be something harmless.
   assign norm = normalize(b_v_ff[23:0]);

   always_comb begin
      logic [32:0] sq;
      lg_vld_in[0]  = b_vld_ff;
      lg_e_in[0]    = b_flg_ff.floored ? 5'd0 : norm[36:32];
      lg_m_in[0]    = b_flg_ff.floored ? 32'h8000_0000 : norm[31:0];
      lg_frac_in[0] = '0;
      lg_flg_in[0]  = b_flg_ff;
      for (int k = 1; k <= LOG_STEPS; k++) begin
         sq            = sq_step(lg_m_ff[k-1]);
         lg_vld_in[k]  = lg_vld_ff[k-1];
         lg_m_in[k]    = sq[31:0];
         lg_frac_in[k] = {lg_frac_ff[k-1][LOG_STEPS-2:0], sq[32]};
         lg_e_in[k]    = lg_e_ff[k-1];
         lg_flg_in[k]  = lg_flg_ff[k-1];
      end
   end

   // Log distance in Q30 and its magnitude. For a floored pixel the distance
   // is log2(white) + log2(100000), taken from the configuration engine.
   assign lv = {lg_e_ff[LOG_STEPS], lg_frac_ff[LOG_STEPS]};

   always_comb begin
      if (lg_flg_ff[LOG_STEPS].floored) begin
         ldiff = 38'(cfg_st.dfloor);
      end else begin
         ldiff = 38'(cfg_st.log2w) + LOG2_256_Q30 - 38'(lv);
      end
      d_vld_in = lg_vld_ff[LOG_STEPS];
      d_neg_in = ldiff[37];
      d_mag_in = ldiff[37] ? 36'(~ldiff + 38'd1) : ldiff[35:0];
      d_flg_in = lg_flg_ff[LOG_STEPS];
   end

   // Scale by ln 2 (Q26). The magnitude is split at bit 32 so each product
   // stays within one ordinary multiplier.
   always_comb begin
      e_vld_in = d_vld_ff;
      e_lo_in  = 58'(d_mag_ff[31:0]) * 58'(LN2_Q26);
      e_hi_in  = 30'(d_mag_ff[35:32]) * 30'(LN2_Q26);
      e_neg_in = d_neg_ff;
      e_flg_in = d_flg_ff;
   end

   // Recombine, round the Q56 magnitude to Q10 with halves away from zero,
   // restore the sign and saturate to 16 bits.
   assign sum = 62'(e_lo_ff) + {e_hi_ff, 32'h0000_0000};
   assign rnd = sum + ROUND_HALF;

   always_comb begin
      rmag = (rnd[61:46] > R_CLAMP) ? R_CLAMP : rnd[61:46];
      if (e_neg_ff) begin
         rsp_in.attenuation = (rmag > NEG_MAG_MAX) ? 16'sh8000 : signed'(16'(~rmag + 16'd1));
      end else begin
         rsp_in.attenuation = (rmag > POS_MAX) ? 16'sh7FFF : signed'(rmag);
      end
      rsp_in.over_white = e_flg_ff.over_white;
      rsp_in.floored    = e_flg_ff.floored;
      rsp_in.last_out   = e_flg_ff.last;
      rsp_valid_in      = e_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         lg_vld_ff    <= '0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         if (adv) begin
            b_vld_ff     <= b_vld_in;
            lg_vld_ff    <= lg_vld_in;
            d_vld_ff     <= d_vld_in;
            e_vld_ff     <= e_vld_in;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
      a_pay_ff <= a_pay_in;
      if (adv) begin
         b_v_ff   <= b_v_in;
         b_flg_ff <= b_flg_in;
         for (int k = 0; k <= LOG_STEPS; k++) begin
            lg_m_ff[k]    <= lg_m_in[k];
            lg_frac_ff[k] <= lg_frac_in[k];
            lg_e_ff[k]    <= lg_e_in[k];
            lg_flg_ff[k]  <= lg_flg_in[k];
         end
         d_mag_ff <= d_mag_in;
         d_neg_ff <= d_neg_in;
         d_flg_ff <= d_flg_in;
         e_lo_ff  <= e_lo_in;
         e_hi_ff  <= e_hi_in;
         e_neg_ff <= e_neg_in;
         e_flg_ff <= e_flg_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_vld_ff)
      else $error("accepted request missing from the input register");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(lg_vld_ff))
      else $error("log chain moved during an output stall");

   a_floor_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.floored |-> !rsp_ff.attenuation[15])
      else $error("floored pixel produced a negative attenuation");

endmodule
